// File: hdl/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Shared widths, limits and structs of the mip subresource layout block.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int unsigned DIM_W          = 15;
  localparam int unsigned LVL_W          = 4;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned ES_W           = 8;
  localparam int unsigned OFS_W          = 44;
  localparam int unsigned ROW_W          = 19;
  localparam int unsigned SLICE_W        = 33;
  localparam int unsigned ROWS_W         = 16;
  localparam int unsigned MUL_A_W        = 19;
  localparam int unsigned MUL_M_W        = 16;
  localparam int unsigned SIZE_W         = 47;

  localparam int unsigned MAX_DIM        = 16384;
  localparam int unsigned MAX_MIP_LEVELS = 15;

  // serial schedule: slice bit j leaves multiplier 1 at count j+1,
  // size bit j leaves multiplier 2 at count j+2
  localparam int unsigned CAP_FIRST      = 1;
  localparam int unsigned ACC_FIRST      = 2;
  localparam int unsigned CNT_LAST       = ACC_FIRST + SIZE_W - 1;
  localparam int unsigned CNT_W          = $clog2(CNT_LAST + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN  = 3'd0,
    KIND_BLOCK  = 3'd1,
    KIND_PAIR   = 3'd2,
    KIND_PLANAR = 3'd3,
    KIND_NV11   = 3'd4,
    KIND_RSVD5  = 3'd5,
    KIND_RSVD6  = 3'd6,
    KIND_RSVD7  = 3'd7
  } msl_kind_e;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [ROWS_W-1:0]  rows;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_M_W-1:0] mul_m;
    logic [DIM_W-1:0]   depth;
  } msl_prep_t;

  typedef struct packed {
    logic accept;
    logic restart;
    logic step;
    logic lo;
    logic fin;
  } msl_acc_ctl_t;

endpackage

// File: hdl/msl_if.sv
// ----------------------------------------------------------------------------
// msl_if
// Valid/ready channels for subresource items and layout results.
// ----------------------------------------------------------------------------
interface msl_in_if;
  logic                           valid;
  logic                           ready;
  logic                           restart;
  logic [msl_pkg::DIM_W-1:0]      base_width;
  logic [msl_pkg::DIM_W-1:0]      base_height;
  logic [msl_pkg::DIM_W-1:0]      base_depth;
  logic [msl_pkg::KIND_W-1:0]     format_kind;
  logic [msl_pkg::ES_W-1:0]       element_size;
  logic [msl_pkg::LVL_W-1:0]      mip_level;
  logic [msl_pkg::OFS_W-1:0]      buffer_bytes;

  modport source (
    output valid, restart, base_width, base_height, base_depth,
           format_kind, element_size, mip_level, buffer_bytes,
    input  ready
  );
  modport sink (
    input  valid, restart, base_width, base_height, base_depth,
           format_kind, element_size, mip_level, buffer_bytes,
    output ready
  );
endinterface

interface msl_out_if;
  logic                           valid;
  logic                           ready;
  logic [msl_pkg::OFS_W-1:0]      byte_offset;
  logic [msl_pkg::ROW_W-1:0]      row_bytes;
  logic [msl_pkg::SLICE_W-1:0]    slice_bytes;
  logic [msl_pkg::ROWS_W-1:0]     num_rows;
  logic                           overrun;

  modport source (
    output valid, byte_offset, row_bytes, slice_bytes, num_rows, overrun,
    input  ready
  );
  modport sink (
    input  valid, byte_offset, row_bytes, slice_bytes, num_rows, overrun,
    output ready
  );
endinterface

// File: hdl/msl_prep.sv
// ----------------------------------------------------------------------------
// msl_prep
// Level dimensions, row pitch, row count and multiplier operands per kind.
// ----------------------------------------------------------------------------
module msl_prep (
  input  logic [msl_pkg::DIM_W-1:0]  base_width_i,
  input  logic [msl_pkg::DIM_W-1:0]  base_height_i,
  input  logic [msl_pkg::DIM_W-1:0]  base_depth_i,
  input  logic [msl_pkg::KIND_W-1:0] format_kind_i,
  input  logic [msl_pkg::ES_W-1:0]   element_size_i,
  input  logic [msl_pkg::LVL_W-1:0]  mip_level_i,
  output msl_pkg::msl_prep_t         prep_o
);

  localparam int unsigned DW = msl_pkg::DIM_W;
  localparam int unsigned LW = msl_pkg::LVL_W;
  localparam int unsigned EW = msl_pkg::ES_W;
  localparam int unsigned PW = DW + EW - 1;

  localparam logic [LW-1:0] LVL_MAX = LW'(msl_pkg::MAX_MIP_LEVELS - 1);
  localparam logic [EW-1:0] BPP_MAX = EW'(128);

  function automatic logic [DW-1:0] level_size(logic [DW-1:0] base, logic [LW-1:0] lvl);
    logic [DW-1:0] v;
    v = (base > DW'(msl_pkg::MAX_DIM)) ? DW'(msl_pkg::MAX_DIM) : base;
    v = v >> lvl;
    if (v == '0) begin
      v = DW'(1);
    end
    return v;
  endfunction

  logic [LW-1:0] lvl;
  logic [DW-1:0] w, h, d;
  logic [DW-1:0] w_p1, w_p3, h_p1, h_p3;
  logic [DW-2:0] w_half, h_half;
  logic [DW-3:0] w_quad, h_quad;
  logic [EW-1:0] bpp;
  logic [PW-1:0] plain_prod, plain_sum;

  assign lvl = (mip_level_i > LVL_MAX) ? LVL_MAX : mip_level_i;
  assign w   = level_size(base_width_i, lvl);
  assign h   = level_size(base_height_i, lvl);
  assign d   = level_size(base_depth_i, lvl);

  // level sizes stay at or below MAX_DIM, so these sums cannot wrap
  assign w_p1   = w + DW'(1);
  assign w_p3   = w + DW'(3);
  assign h_p1   = h + DW'(1);
  assign h_p3   = h + DW'(3);
  assign w_half = w_p1[DW-1:1];
  assign h_half = h_p1[DW-1:1];
  assign w_quad = w_p3[DW-1:2];
  assign h_quad = h_p3[DW-1:2];

  assign bpp        = (element_size_i > BPP_MAX) ? BPP_MAX : element_size_i;
  assign plain_prod = PW'(w) * PW'(bpp);
  assign plain_sum  = plain_prod + PW'(7);

  always_comb begin
    prep_o.depth = d;
    unique case (format_kind_i)
      msl_pkg::KIND_BLOCK: begin
        if (element_size_i > EW'(8)) begin
          prep_o.row = msl_pkg::ROW_W'({w_quad, 4'b0000});
        end else begin
          prep_o.row = msl_pkg::ROW_W'({w_quad, 3'b000});
        end
        prep_o.rows  = msl_pkg::ROWS_W'(h_quad);
        prep_o.mul_a = msl_pkg::MUL_A_W'(prep_o.row);
        prep_o.mul_m = msl_pkg::MUL_M_W'(h_quad);
      end
      msl_pkg::KIND_PAIR: begin
        if (element_size_i > EW'(4)) begin
          prep_o.row = msl_pkg::ROW_W'({w_half, 3'b000});
        end else begin
          prep_o.row = msl_pkg::ROW_W'({w_half, 2'b00});
        end
        prep_o.rows  = msl_pkg::ROWS_W'(h);
        prep_o.mul_a = msl_pkg::MUL_A_W'(prep_o.row);
        prep_o.mul_m = msl_pkg::MUL_M_W'(h);
      end
      msl_pkg::KIND_PLANAR: begin
        // row is always even: slice = (row/2) * 3h
        if (element_size_i > EW'(2)) begin
          prep_o.mul_a = msl_pkg::MUL_A_W'({w_half, 1'b0});
        end else begin
          prep_o.mul_a = msl_pkg::MUL_A_W'(w_half);
        end
        prep_o.row   = msl_pkg::ROW_W'({prep_o.mul_a, 1'b0});
        prep_o.rows  = msl_pkg::ROWS_W'(h) + msl_pkg::ROWS_W'(h_half);
        prep_o.mul_m = msl_pkg::MUL_M_W'(h) + msl_pkg::MUL_M_W'({h, 1'b0});
      end
      msl_pkg::KIND_NV11: begin
        prep_o.row   = msl_pkg::ROW_W'({w_quad, 2'b00});
        prep_o.rows  = msl_pkg::ROWS_W'({h, 1'b0});
        prep_o.mul_a = msl_pkg::MUL_A_W'(prep_o.row);
        prep_o.mul_m = msl_pkg::MUL_M_W'({h, 1'b0});
      end
      default: begin
        prep_o.row   = plain_sum[PW-1:3];
        prep_o.rows  = msl_pkg::ROWS_W'(h);
        prep_o.mul_a = msl_pkg::MUL_A_W'(prep_o.row);
        prep_o.mul_m = msl_pkg::MUL_M_W'(h);
      end
    endcase
  end

endmodule

// File: hdl/msl_ser_mul.sv
// ----------------------------------------------------------------------------
// msl_ser_mul
// Serial-parallel multiplier: multiplicand enters LSB first, one bit per
// cycle while en_i is high, against a parallel operand; product leaves LSB first, registered.
// ----------------------------------------------------------------------------
module msl_ser_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        en_i,
  input  logic [msl_pkg::MUL_M_W-1:0] op_i,
  input  logic                        bit_i,
  output logic                        bit_o
);

  localparam int unsigned MW = msl_pkg::MUL_M_W;

  logic [MW-1:0] acc_q;
  logic          out_q;
  logic [MW:0]   sum;

  assign sum   = {1'b0, acc_q} + ({1'b0, op_i} & {(MW + 1){bit_i}});
  assign bit_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      out_q <= 1'b0;
    end else if (clr_i) begin
      acc_q <= '0;
      out_q <= 1'b0;
    end else if (en_i) begin
      acc_q <= sum[MW:1];
      out_q <= sum[0];
    end
  end

endmodule

// File: hdl/msl_ser_acc.sv
// ----------------------------------------------------------------------------
// msl_ser_acc
// Running offset and sticky overrun: bit-serial offset add, buffer compare
// and saturation, one bit of the subresource size per step.
// ----------------------------------------------------------------------------
module msl_ser_acc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  msl_pkg::msl_acc_ctl_t     ctl_i,
  input  logic [msl_pkg::OFS_W-1:0] buf_i,
  input  logic                      size_bit_i,
  output logic [msl_pkg::OFS_W-1:0] ofs_o,
  output logic                      ovr_o
);

  localparam int unsigned OW = msl_pkg::OFS_W;

  logic [OW-1:0] ofs_q;
  logic [OW-1:0] buf_q;
  logic          ovr_q;
  logic          carry_q, gt_q, hi_q;
  logic          a_bit, b_bit, e_bit;
  logic          carry_d, gt_d, hi_d;

  assign a_bit   = ctl_i.lo & ofs_q[0];
  assign b_bit   = buf_q[0];
  assign e_bit   = size_bit_i ^ a_bit ^ carry_q;
  assign carry_d = (size_bit_i & a_bit) | (size_bit_i & carry_q) | (a_bit & carry_q);
  assign gt_d    = (e_bit & ~b_bit) | (~(e_bit ^ b_bit) & gt_q);
  assign hi_d    = hi_q | (~ctl_i.lo & e_bit);

  assign ofs_o = ofs_q;
  assign ovr_o = ovr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0;
      ovr_q <= 1'b0;
    end else if (ctl_i.accept) begin
      if (ctl_i.restart) begin
        ofs_q <= '0;
        ovr_q <= 1'b0;
      end
    end else if (ctl_i.step) begin
      if (ctl_i.lo) begin
        ofs_q <= {e_bit, ofs_q[OW-1:1]};
      end
      if (ctl_i.fin) begin
        ovr_q <= ovr_q | gt_d;
        if (hi_d) begin
          ofs_q <= '1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      buf_q   <= buf_i;
      carry_q <= 1'b0;
      gt_q    <= 1'b0;
      hi_q    <= 1'b0;
    end else if (ctl_i.step) begin
      buf_q   <= {1'b0, buf_q[OW-1:1]};
      carry_q <= carry_d;
      gt_q    <= gt_d;
      hi_q    <= hi_d;
    end
  end

endmodule

// File: hdl/mip_subresource_layout.sv
// ----------------------------------------------------------------------------
// mip_subresource_layout
// Mip-chain subresource layout: level sizes, row pitch, slice size, running
// byte offset and sticky overrun for one subresource per item.
// One item is in work at a time: a new item is accepted only in the idle
// state, after the bit-serial size chain (47-bit size stream through two
// serial multipliers and the offset adder) has finished the last one.
// A waiting result does not block the next item until that item finishes.
// Reset: asynchronous, clears running offset, overrun flag and control.
// ----------------------------------------------------------------------------
module mip_subresource_layout (
  input  logic         clk_i,
  input  logic         rst_ni,
  msl_in_if.sink       in_i,
  msl_out_if.source    out_o
);

  localparam int unsigned CW = msl_pkg::CNT_W;

  localparam logic [CW-1:0] CAP_FIRST = CW'(msl_pkg::CAP_FIRST);
  localparam logic [CW-1:0] CAP_LAST  = CW'(msl_pkg::CAP_FIRST + msl_pkg::SLICE_W - 1);
  localparam logic [CW-1:0] ACC_FIRST = CW'(msl_pkg::ACC_FIRST);
  localparam logic [CW-1:0] ACC_LO    = CW'(msl_pkg::ACC_FIRST + msl_pkg::OFS_W);
  localparam logic [CW-1:0] CNT_LAST  = CW'(msl_pkg::CNT_LAST);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                            state_q;
  logic [CW-1:0]                     cnt_q;
  logic                              out_valid_q;
  logic [msl_pkg::OFS_W-1:0]         byte_offset_q;
  logic [msl_pkg::ROW_W-1:0]         row_bytes_q;
  logic [msl_pkg::SLICE_W-1:0]       slice_bytes_q;
  logic [msl_pkg::ROWS_W-1:0]        num_rows_q;
  logic                              overrun_q;

  logic [msl_pkg::DIM_W-1:0]         base_w_q, base_h_q, base_d_q;
  logic [msl_pkg::KIND_W-1:0]        kind_q;
  logic [msl_pkg::ES_W-1:0]          es_q;
  logic [msl_pkg::LVL_W-1:0]         lvl_q;
  logic [msl_pkg::ROW_W-1:0]         row_q;
  logic [msl_pkg::ROWS_W-1:0]        rows_q;
  logic [msl_pkg::MUL_M_W-1:0]       mul_m_q;
  logic [msl_pkg::DIM_W-1:0]         depth_q;
  logic [msl_pkg::MUL_A_W-1:0]       a_sh_q;
  logic [msl_pkg::SLICE_W-1:0]       slice_q;
  logic [msl_pkg::OFS_W-1:0]         start_q;

  msl_pkg::msl_prep_t                prep;
  msl_pkg::msl_acc_ctl_t             acc_ctl;
  logic                              in_acc, out_free, run, slice_cap;
  logic                              mul1_bit, mul2_bit;
  logic [msl_pkg::OFS_W-1:0]         acc_ofs;
  logic                              acc_ovr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;
  assign run        = (state_q == ST_RUN);
  assign slice_cap  = run & (cnt_q >= CAP_FIRST) & (cnt_q <= CAP_LAST);

  assign acc_ctl.accept  = in_acc;
  assign acc_ctl.restart = in_i.restart;
  assign acc_ctl.step    = run & (cnt_q >= ACC_FIRST);
  assign acc_ctl.lo      = (cnt_q < ACC_LO);
  assign acc_ctl.fin     = run & (cnt_q == CNT_LAST);

  msl_prep u_prep (
    .base_width_i   (base_w_q),
    .base_height_i  (base_h_q),
    .base_depth_i   (base_d_q),
    .format_kind_i  (kind_q),
    .element_size_i (es_q),
    .mip_level_i    (lvl_q),
    .prep_o         (prep)
  );

  msl_ser_mul u_mul_slice (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (state_q == ST_PREP),
    .en_i   (run),
    .op_i   (mul_m_q),
    .bit_i  (a_sh_q[0]),
    .bit_o  (mul1_bit)
  );

  msl_ser_mul u_mul_size (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (state_q == ST_PREP),
    .en_i   (run),
    .op_i   (msl_pkg::MUL_M_W'(depth_q)),
    .bit_i  (mul1_bit),
    .bit_o  (mul2_bit)
  );

  msl_ser_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (acc_ctl),
    .buf_i      (in_i.buffer_bytes),
    .size_bit_i (mul2_bit),
    .ofs_o      (acc_ofs),
    .ovr_o      (acc_ovr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      byte_offset_q <= '0;
      row_bytes_q   <= '0;
      slice_bytes_q <= '0;
      num_rows_q    <= '0;
      overrun_q     <= 1'b0;
    end else begin
      if (out_o.ready && !((state_q == ST_DONE) && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          cnt_q   <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            byte_offset_q <= start_q;
            row_bytes_q   <= row_q;
            slice_bytes_q <= slice_q;
            num_rows_q    <= rows_q;
            overrun_q     <= acc_ovr;
            state_q       <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_w_q <= in_i.base_width;
      base_h_q <= in_i.base_height;
      base_d_q <= in_i.base_depth;
      kind_q   <= in_i.format_kind;
      es_q     <= in_i.element_size;
      lvl_q    <= in_i.mip_level;
    end
    if (state_q == ST_PREP) begin
      row_q   <= prep.row;
      rows_q  <= prep.rows;
      mul_m_q <= prep.mul_m;
      depth_q <= prep.depth;
      a_sh_q  <= prep.mul_a;
      start_q <= acc_ofs;
    end
    if (run) begin
      a_sh_q <= {1'b0, a_sh_q[msl_pkg::MUL_A_W-1:1]};
    end
    if (slice_cap) begin
      slice_q <= {mul1_bit, slice_q[msl_pkg::SLICE_W-1:1]};
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.byte_offset = byte_offset_q;
  assign out_o.row_bytes   = row_bytes_q;
  assign out_o.slice_bytes = slice_bytes_q;
  assign out_o.num_rows    = num_rows_q;
  assign out_o.overrun     = overrun_q;

endmodule

// File: hdl/msl_chk.sv
// ----------------------------------------------------------------------------
// msl_chk
// Port-level checks of the mip subresource layout block, bound to the top.
// ----------------------------------------------------------------------------
module msl_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [msl_pkg::OFS_W-1:0]    byte_offset_i,
  input logic [msl_pkg::ROW_W-1:0]    row_bytes_i,
  input logic [msl_pkg::SLICE_W-1:0]  slice_bytes_i,
  input logic [msl_pkg::ROWS_W-1:0]   num_rows_i,
  input logic                         overrun_i
);

  logic in_acc;

  assign in_acc = in_valid_i & in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(byte_offset_i) && $stable(row_bytes_i)
      && $stable(slice_bytes_i) && $stable(num_rows_i) && $stable(overrun_i))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared right after accept");

endmodule

bind mip_subresource_layout msl_chk u_msl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .byte_offset_i (out_o.byte_offset),
  .row_bytes_i   (out_o.row_bytes),
  .slice_bytes_i (out_o.slice_bytes),
  .num_rows_i    (out_o.num_rows),
  .overrun_i     (out_o.overrun)
);
